[src/imucal_pkg.sv]
`timescale 1ns / 1ps

package imucal_pkg;

	localparam int NUM_AXES = 6;
	localparam int SMP_W    = 16;
	localparam int SUM_W    = 28;
	localparam int DVD_W    = SUM_W + 1;
	localparam int DSR_W    = 13;
	localparam int OFS_W    = 16;
	localparam int CIDX_W   = 3;
	localparam int CDAT_W   = 15;

	localparam logic [CIDX_W-1:0] CFG_WINDOW_LENGTH     = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_SETTLE_SAMPLES    = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_ACCEL_DEADZONE    = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_GYRO_DEADZONE     = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_GRAVITY_REFERENCE = 3'd4;

	localparam logic [12:0] WL_RESET     = 13'd1000;
	localparam logic [7:0]  SETTLE_RESET = 8'd101;
	localparam logic [7:0]  ADZ_RESET    = 8'd8;
	localparam logic [7:0]  GDZ_RESET    = 8'd2;
	localparam logic [14:0] GRAV_RESET   = 15'd16384;

	localparam logic [DSR_W-1:0] ACCEL_FIRST_DIV = 13'd8;
	localparam logic [DSR_W-1:0] GYRO_FIRST_DIV  = 13'd4;

	localparam logic [2:0] GRAV_AXIS = 3'd2;
	localparam logic [2:0] LAST_AXIS = 3'd5;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_REFINE,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_ERR_GO,
		ST_ERR_WAIT,
		ST_UPD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic sample;
		logic div_start;
		logic div_err;
		logic cap_mean;
		logic upd_axis;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic win_end;
		logic div_done;
		logic last_axis;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] accel_x;
		logic signed [SMP_W-1:0] accel_y;
		logic signed [SMP_W-1:0] accel_z;
		logic signed [SMP_W-1:0] gyro_x;
		logic signed [SMP_W-1:0] gyro_y;
		logic signed [SMP_W-1:0] gyro_z;
		logic                    restart;
	} sample_t;

	typedef struct packed {
		logic signed [OFS_W-1:0] accel_x_offset;
		logic signed [OFS_W-1:0] accel_y_offset;
		logic signed [OFS_W-1:0] accel_z_offset;
		logic signed [OFS_W-1:0] gyro_x_offset;
		logic signed [OFS_W-1:0] gyro_y_offset;
		logic signed [OFS_W-1:0] gyro_z_offset;
		logic                    converged;
		logic [15:0]             pass_index;
	} result_t;

	function automatic logic signed [OFS_W-1:0] sat16(input logic signed [29:0] v);
		logic signed [OFS_W-1:0] r;
		if (v > 30'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -30'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[OFS_W-1:0];
		end
		return r;
	endfunction

endpackage

[src/imucal_sample_if.sv]
`timescale 1ns / 1ps

interface imucal_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic               restart;

	modport source (
		output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, restart,
		input  ready
	);
	modport sink (
		input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, restart,
		output ready
	);
endinterface

[src/imucal_result_if.sv]
`timescale 1ns / 1ps

interface imucal_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x_offset;
	logic signed [15:0] accel_y_offset;
	logic signed [15:0] accel_z_offset;
	logic signed [15:0] gyro_x_offset;
	logic signed [15:0] gyro_y_offset;
	logic signed [15:0] gyro_z_offset;
	logic               converged;
	logic [15:0]        pass_index;

	modport source (
		output valid, accel_x_offset, accel_y_offset, accel_z_offset,
			gyro_x_offset, gyro_y_offset, gyro_z_offset, converged, pass_index,
		input  ready
	);
	modport sink (
		input  valid, accel_x_offset, accel_y_offset, accel_z_offset,
			gyro_x_offset, gyro_y_offset, gyro_z_offset, converged, pass_index,
		output ready
	);
endinterface

[src/imucal_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Truncates toward zero.
// Divisor is always positive here, so only the dividend sign matters.
module imucal_div import imucal_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0]        divisor,
	output logic                    done,
	output logic signed [DVD_W-1:0] quotient
);

	localparam int StepW = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [StepW-1:0] step_q;
	logic [DVD_W-1:0] quo_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic             neg_q;

	logic [DVD_W-1:0] mag_c;
	logic [DSR_W:0]   trial_c;
	logic             fits_c;

	assign mag_c   = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
	assign trial_c = {rem_q, quo_q[DVD_W-1]};
	assign fits_c  = trial_c >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= StepW'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == StepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag_c;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[DVD_W-1];
		end else if (busy_q) begin
			if (fits_c) begin
				rem_q <= DSR_W'(trial_c - {1'b0, dsr_q});
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial_c[DSR_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

[src/imucal_dp.sv]
`timescale 1ns / 1ps

module imucal_dp import imucal_pkg::*; #(
	parameter int MAX_WINDOW  = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CDAT_W-1:0] cfg_wdata,
	input  sample_t           smp,
	input  cmd_t              cmd,
	output status_t           stat,
	input  logic              out_ready,
	output logic              out_valid,
	output result_t           res
);

	// window length register is 13 bits, so the usable maximum is capped there too
	localparam int EffMax = (MAX_WINDOW < ((1 << DSR_W) - 1)) ? MAX_WINDOW : ((1 << DSR_W) - 1);
	localparam int CntW   = $clog2(EffMax + 256);
	localparam logic [DSR_W-1:0] WlMax = DSR_W'(EffMax);

	// configuration
	logic [12:0] wl_q;
	logic [7:0]  settle_q;
	logic [7:0]  adz_q;
	logic [7:0]  gdz_q;
	logic [14:0] grav_q;

	// state
	logic signed [SUM_W-1:0] sums_q [NUM_AXES];
	logic signed [OFS_W-1:0] offs_q [NUM_AXES];
	logic [CntW-1:0]         cnt_q;
	phase_t                  phase_q;
	logic [15:0]             wcount_q;
	logic [2:0]              axis_q;
	logic signed [SUM_W-1:0] mean_q;
	logic signed [DVD_W-1:0] err_q;
	logic [NUM_AXES-1:0]     pass_q;
	logic                    out_valid_q;
	result_t                 res_q;

	logic [DSR_W-1:0]        wl_eff;
	logic [CntW-1:0]         last_c;
	logic [7:0]              adz_eff;
	phase_t                  phase_eff;
	logic [CntW-1:0]         cnt_eff;
	logic                    active_c;
	logic                    accum_c;
	logic                    win_end_c;
	logic signed [SMP_W-1:0] smp_a [NUM_AXES];
	logic signed [SUM_W-1:0] acc_c [NUM_AXES];

	logic signed [DVD_W-1:0] err_c;
	logic signed [DVD_W-1:0] dvd_c;
	logic [DSR_W-1:0]        dsr_c;
	logic                    accel_axis;
	logic                    div_done;
	logic signed [DVD_W-1:0] quo;
	logic [DVD_W-1:0]        mag_c;
	logic [7:0]              dz_c;
	logic                    pass_c;
	logic signed [OFS_W-1:0] new_off_c;
	logic                    out_free_c;

	function automatic logic signed [DVD_W-1:0] sext_smp(input logic [SMP_W-1:0] f);
		return {{(DVD_W - SAMPLE_BITS){f[SAMPLE_BITS-1]}}, f[SAMPLE_BITS-1:0]};
	endfunction

	always_comb begin
		if (wl_q == '0) begin
			wl_eff = DSR_W'(1);
		end else if (wl_q > WlMax) begin
			wl_eff = WlMax;
		end else begin
			wl_eff = wl_q;
		end
	end

	assign last_c  = CntW'(settle_q) + CntW'(wl_eff) - CntW'(1);
	assign adz_eff = (adz_q == '0) ? 8'd1 : adz_q;

	assign smp_a[0] = smp.accel_x;
	assign smp_a[1] = smp.accel_y;
	assign smp_a[2] = smp.accel_z;
	assign smp_a[3] = smp.gyro_x;
	assign smp_a[4] = smp.gyro_y;
	assign smp_a[5] = smp.gyro_z;

	// restart acts before the sample is looked at
	assign phase_eff = smp.restart ? PH_FIRST : phase_q;
	assign cnt_eff   = smp.restart ? '0 : cnt_q;
	assign active_c  = (phase_eff == PH_FIRST) || (phase_eff == PH_REFINE);
	assign accum_c   = active_c && (cnt_eff >= CntW'(settle_q));
	assign win_end_c = active_c && (cnt_eff >= last_c);

	always_comb begin
		logic signed [SUM_W-1:0] base;
		logic signed [DVD_W-1:0] t;
		for (int k = 0; k < NUM_AXES; k++) begin
			base = smp.restart ? '0 : sums_q[k];
			t    = {base[SUM_W-1], base} + sext_smp(smp_a[k]);
			if (!accum_c) begin
				acc_c[k] = base;
			end else if (t[DVD_W-1] != t[SUM_W-1]) begin
				acc_c[k] = {t[DVD_W-1], {(SUM_W-1){~t[DVD_W-1]}}};
			end else begin
				acc_c[k] = t[SUM_W-1:0];
			end
		end
	end

	// window-end arithmetic, one axis at a time through the shared divider
	assign accel_axis = axis_q < 3'd3;
	assign err_c = (axis_q == GRAV_AXIS) ?
		$signed({14'b0, grav_q}) - {mean_q[SUM_W-1], mean_q} :
		-{mean_q[SUM_W-1], mean_q};

	always_comb begin
		if (!cmd.div_err) begin
			dvd_c = {sums_q[axis_q][SUM_W-1], sums_q[axis_q]};
			dsr_c = wl_eff;
		end else begin
			dvd_c = err_c;
			if (phase_q == PH_FIRST) begin
				dsr_c = accel_axis ? ACCEL_FIRST_DIV : GYRO_FIRST_DIV;
			end else begin
				dsr_c = accel_axis ? DSR_W'(adz_eff) : DSR_W'({1'b0, gdz_q} + 9'd1);
			end
		end
	end

	imucal_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd_c),
		.divisor  (dsr_c),
		.done     (div_done),
		.quotient (quo)
	);

	assign mag_c  = err_q[DVD_W-1] ? DVD_W'(-err_q) : DVD_W'(err_q);
	assign dz_c   = accel_axis ? adz_eff : gdz_q;
	assign pass_c = mag_c <= {{(DVD_W-8){1'b0}}, dz_c};

	always_comb begin
		if (phase_q == PH_FIRST) begin
			new_off_c = sat16({quo[DVD_W-1], quo});
		end else if (pass_c) begin
			new_off_c = offs_q[axis_q];
		end else begin
			new_off_c = sat16({{14{offs_q[axis_q][OFS_W-1]}}, offs_q[axis_q]} +
				{quo[DVD_W-1], quo});
		end
	end

	assign out_free_c = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q     <= WL_RESET;
			settle_q <= SETTLE_RESET;
			adz_q    <= ADZ_RESET;
			gdz_q    <= GDZ_RESET;
			grav_q   <= GRAV_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_LENGTH:     wl_q     <= cfg_wdata[12:0];
				CFG_SETTLE_SAMPLES:    settle_q <= cfg_wdata[7:0];
				CFG_ACCEL_DEADZONE:    adz_q    <= cfg_wdata[7:0];
				CFG_GYRO_DEADZONE:     gdz_q    <= cfg_wdata[7:0];
				CFG_GRAVITY_REFERENCE: grav_q   <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				sums_q[k] <= '0;
				offs_q[k] <= '0;
			end
			cnt_q       <= '0;
			phase_q     <= PH_FIRST;
			wcount_q    <= '0;
			axis_q      <= '0;
			pass_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sample) begin
				for (int k = 0; k < NUM_AXES; k++) begin
					sums_q[k] <= acc_c[k];
					if (smp.restart) begin
						offs_q[k] <= '0;
					end
				end
				if (smp.restart) begin
					phase_q  <= PH_FIRST;
					wcount_q <= '0;
				end
				if (active_c) begin
					cnt_q <= win_end_c ? cnt_eff : cnt_eff + 1'b1;
				end
			end
			if (cmd.upd_axis) begin
				sums_q[axis_q] <= '0;
				offs_q[axis_q] <= new_off_c;
				pass_q[axis_q] <= pass_c;
				axis_q         <= axis_q + 1'b1;
			end
			if (cmd.finish) begin
				cnt_q       <= '0;
				axis_q      <= '0;
				out_valid_q <= 1'b1;
				if (wcount_q != 16'hFFFF) begin
					wcount_q <= wcount_q + 1'b1;
				end
				if (phase_q == PH_FIRST) begin
					phase_q <= PH_REFINE;
				end else if (&pass_q) begin
					phase_q <= PH_DONE;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_mean) begin
			mean_q <= quo[SUM_W-1:0];
		end
		if (cmd.div_start && cmd.div_err) begin
			err_q <= err_c;
		end
		if (cmd.finish) begin
			res_q.accel_x_offset <= offs_q[0];
			res_q.accel_y_offset <= offs_q[1];
			res_q.accel_z_offset <= offs_q[2];
			res_q.gyro_x_offset  <= offs_q[3];
			res_q.gyro_y_offset  <= offs_q[4];
			res_q.gyro_z_offset  <= offs_q[5];
			res_q.converged      <= (phase_q == PH_REFINE) && (&pass_q);
			res_q.pass_index     <= (wcount_q != 16'hFFFF) ? wcount_q + 1'b1 : wcount_q;
		end
	end

	assign stat.win_end   = win_end_c;
	assign stat.div_done  = div_done;
	assign stat.last_axis = axis_q == LAST_AXIS;
	assign stat.out_free  = out_free_c;

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

[src/imucal_ctrl.sv]
`timescale 1ns / 1ps

module imucal_ctrl import imucal_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t stat,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && stat.win_end) begin
					state_d = ST_MEAN_GO;
				end
			end
			ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
			ST_MEAN_WAIT: begin
				if (stat.div_done) begin
					state_d = ST_ERR_GO;
				end
			end
			ST_ERR_GO:    state_d = ST_ERR_WAIT;
			ST_ERR_WAIT: begin
				if (stat.div_done) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD:       state_d = stat.last_axis ? ST_OUT : ST_MEAN_GO;
			ST_OUT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.sample = in_valid;
			end
			ST_MEAN_GO:   cmd.div_start = 1'b1;
			ST_MEAN_WAIT: cmd.cap_mean  = stat.div_done;
			ST_ERR_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_err   = 1'b1;
			end
			ST_UPD:       cmd.upd_axis  = 1'b1;
			ST_OUT:       cmd.finish    = stat.out_free;
			default: ;
		endcase
	end

endmodule

[src/imu_offset_calibrator.sv]
// Samples are taken one per cycle while no window is being processed.
// An item that closes a window triggers two serial 29-step divisions per axis on one
// shared divider (mean, then offset step); no items are taken until the result is registered.
// The result sits in an output register, so the next window starts while it waits.
// Reset (arst_n low, asynchronous) restores the default registers, zeroes all offsets,
// sums and counters, and starts over with a first window.
`timescale 1ns / 1ps

module imu_offset_calibrator import imucal_pkg::*; #(
	parameter int MAX_WINDOW  = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	imucal_sample_if.sink       sample,
	imucal_result_if.source     result,
	input  logic                cfg_we,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CDAT_W-1:0]   cfg_wdata
);

	sample_t smp;
	result_t res;
	cmd_t    cmd;
	status_t stat;
	logic    in_ready;
	logic    out_valid;

	assign smp.accel_x = sample.accel_x;
	assign smp.accel_y = sample.accel_y;
	assign smp.accel_z = sample.accel_z;
	assign smp.gyro_x  = sample.gyro_x;
	assign smp.gyro_y  = sample.gyro_y;
	assign smp.gyro_z  = sample.gyro_z;
	assign smp.restart = sample.restart;
	assign sample.ready = in_ready;

	imucal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	imucal_dp #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.smp       (smp),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (result.ready),
		.out_valid (out_valid),
		.res       (res)
	);

	assign result.valid          = out_valid;
	assign result.accel_x_offset = res.accel_x_offset;
	assign result.accel_y_offset = res.accel_y_offset;
	assign result.accel_z_offset = res.accel_z_offset;
	assign result.gyro_x_offset  = res.gyro_x_offset;
	assign result.gyro_y_offset  = res.gyro_y_offset;
	assign result.gyro_z_offset  = res.gyro_z_offset;
	assign result.converged      = res.converged;
	assign result.pass_index     = res.pass_index;

endmodule

[src/imucal_checker.sv]
`timescale 1ns / 1ps

module imucal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_valid,
	input logic        s_ready,
	input logic        r_valid,
	input logic        r_ready,
	input logic        r_converged,
	input logic [15:0] r_pass_index,
	input logic [15:0] r_ax,
	input logic [15:0] r_ay,
	input logic [15:0] r_az,
	input logic [15:0] r_gx,
	input logic [15:0] r_gy,
	input logic [15:0] r_gz
);

	// the first window only sets offsets, so convergence needs at least two windows
	a_conv_after_refine: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_converged |-> r_pass_index >= 16'd2)
		else $error("converged reported before a refine window");

	// input side only closes after taking an item that ends a window
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_ready) |-> $past(s_valid))
		else $error("input ready dropped without an accepted item");

	// a new result appears only at the end of window processing, when input was held off
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> $past(!s_ready))
		else $error("result appeared without window processing");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_pass_index) && $stable(r_converged)
			&& $stable(r_ax) && $stable(r_ay) && $stable(r_az)
			&& $stable(r_gx) && $stable(r_gy) && $stable(r_gz))
		else $error("stalled result item changed");

endmodule

bind imu_offset_calibrator imucal_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_valid      (sample.valid),
	.s_ready      (sample.ready),
	.r_valid      (result.valid),
	.r_ready      (result.ready),
	.r_converged  (result.converged),
	.r_pass_index (result.pass_index),
	.r_ax         (result.accel_x_offset),
	.r_ay         (result.accel_y_offset),
	.r_az         (result.accel_z_offset),
	.r_gx         (result.gyro_x_offset),
	.r_gy         (result.gyro_y_offset),
	.r_gz         (result.gyro_z_offset)
);
